### sv/sbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and codes for the s-expression byte tokenizer
// Counter widths, scan modes, event codes, character codes and the
// structs passed between the step logic, the result queue and the top.
// ----------------------------------------------------------------------------
package sbt_pkg;

  // Counter widths
  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 16;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int CNT_BITS   = 3;

  // Scan modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_INTEGER = 2'd2;
  localparam logic [1:0] MODE_IDENT   = 2'd3;

  // Event codes
  localparam logic [2:0] EV_TEXT   = 3'd0;
  localparam logic [2:0] EV_DONE   = 3'd1;
  localparam logic [2:0] EV_LPAREN = 3'd2;
  localparam logic [2:0] EV_RPAREN = 3'd3;
  localparam logic [2:0] EV_END    = 3'd4;

  // Token kinds
  localparam logic KIND_IDENT   = 1'b0;
  localparam logic KIND_INTEGER = 1'b1;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Scanner state
  typedef struct packed {
    logic [1:0]             mode;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
  } state_t;

  // One result item
  typedef struct packed {
    logic [2:0]             event_res;
    logic                   token_kind;
    logic [7:0]             text_byte;
    logic [LINE_BITS-1:0]   token_line;
    logic [COLUMN_BITS-1:0] token_column;
    logic                   last;
  } res_t;

  // Everything one input byte produces
  typedef struct packed {
    state_t     nxt;
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } step_t;

endpackage

### sv/sbt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_in_if: source byte channel
// Valid/ready channel carrying one source byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface sbt_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_input;

  modport source (output valid, output byte_value, output end_of_input, input ready);
  modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

### sv/sbt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_out_if: token event channel
// Valid/ready channel carrying one token event with its position.
// ----------------------------------------------------------------------------
interface sbt_out_if import sbt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             event_res;
  logic                   token_kind;
  logic [7:0]             text_byte;
  logic [LINE_BITS-1:0]   token_line;
  logic [COLUMN_BITS-1:0] token_column;
  logic                   last;

  modport source (output valid, output event_res, output token_kind, output text_byte,
                  output token_line, output token_column, output last, input ready);
  modport sink   (input valid, input event_res, input token_kind, input text_byte,
                  input token_line, input token_column, input last, output ready);
endinterface

### sv/sbt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_step: per-byte scanner logic
// Counts the byte, runs the scan mode for it and, where a token ends,
// handles the same byte again from idle. Gives up to two results.
// ----------------------------------------------------------------------------
module sbt_step import sbt_pkg::*; (
  input  state_t     state,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  output step_t      step
);

  logic [LINE_BITS-1:0]   lc;
  logic [COLUMN_BITS-1:0] cc;
  logic                   is_digit;
  logic                   is_blank;
  logic                   is_sep;

  logic       idle_valid;
  logic       idle_start;
  logic [1:0] idle_mode;
  res_t       idle_res;

  // Classify the byte
  assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  assign is_blank = (byte_value == CH_SPACE) || (byte_value == CH_TAB) ||
                    (byte_value == CH_NL);
  assign is_sep   = is_blank || (byte_value == CH_CR) || (byte_value == CH_VT) ||
                    (byte_value == CH_FF) || (byte_value == CH_LPAREN) ||
                    (byte_value == CH_RPAREN);

  // Count the byte: newline bumps the line and clears the column, anything else bumps the column
  always_comb begin
    lc = state.line;
    cc = state.column;
    if (!end_of_input) begin
      if (byte_value == CH_NL) begin
        if (state.line != {LINE_BITS{1'b1}}) lc = state.line + LINE_BITS'(1);
        cc = '0;
      end else if (state.column != {COLUMN_BITS{1'b1}}) begin
        cc = state.column + COLUMN_BITS'(1);
      end
    end
  end

  // Handle the byte from idle
  always_comb begin
    idle_valid = 1'b0;
    idle_start = 1'b0;
    idle_mode  = MODE_IDLE;
    idle_res   = '0;
    idle_res.token_line   = lc;
    idle_res.token_column = cc;
    priority if (end_of_input) begin
      idle_valid         = 1'b1;
      idle_res.event_res = EV_END;
    end else if (is_blank) begin
      idle_valid = 1'b0;
    end else if (byte_value == CH_LPAREN) begin
      idle_valid         = 1'b1;
      idle_res.event_res = EV_LPAREN;
    end else if (byte_value == CH_RPAREN) begin
      idle_valid         = 1'b1;
      idle_res.event_res = EV_RPAREN;
    end else if (byte_value == CH_SEMI) begin
      idle_mode = MODE_COMMENT;
    end else begin
      idle_valid          = 1'b1;
      idle_start          = 1'b1;
      idle_mode           = is_digit ? MODE_INTEGER : MODE_IDENT;
      idle_res.event_res  = EV_TEXT;
      idle_res.token_kind = is_digit ? KIND_INTEGER : KIND_IDENT;
      idle_res.text_byte  = byte_value;
    end
  end

  // Run the current mode; a token end falls through to the idle result
  always_comb begin
    step            = '0;
    step.nxt        = state;
    step.nxt.line   = lc;
    step.nxt.column = cc;
    step.first.token_line   = state.start_line;
    step.first.token_column = state.start_column;
    unique case (state.mode)
      MODE_COMMENT: begin
        if (end_of_input) begin
          step.nxt.mode = idle_mode;
          step.first    = idle_res;
          step.count    = 2'd1;
        end else if (byte_value == CH_NL) begin
          step.nxt.mode = MODE_IDLE;
        end
      end
      MODE_INTEGER, MODE_IDENT: begin
        step.first.token_kind = (state.mode == MODE_INTEGER) ? KIND_INTEGER : KIND_IDENT;
        if (!end_of_input && ((state.mode == MODE_INTEGER) ? is_digit : !is_sep)) begin
          step.first.event_res = EV_TEXT;
          step.first.text_byte = byte_value;
          step.count           = 2'd1;
        end else begin
          step.first.event_res = EV_DONE;
          step.nxt.mode        = idle_mode;
          step.second          = idle_res;
          step.count           = idle_valid ? 2'd2 : 2'd1;
          if (idle_start) begin
            step.nxt.start_line   = lc;
            step.nxt.start_column = cc;
          end
        end
      end
      MODE_IDLE: begin
        step.nxt.mode = idle_mode;
        step.first    = idle_res;
        step.count    = idle_valid ? 2'd1 : 2'd0;
        if (idle_start) begin
          step.nxt.start_line   = lc;
          step.nxt.start_column = cc;
        end
      end
      default: step.count = 2'd0;
    endcase
    // Flag the final result of this byte
    if (step.count == 2'd1) step.first.last = 1'b1;
    if (step.count == 2'd2) step.second.last = 1'b1;
  end

endmodule

### sv/sbt_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_res_fifo: result queue
// Takes up to two results a cycle and hands out one per output transfer.
// ----------------------------------------------------------------------------
module sbt_res_fifo import sbt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  res_t                push_first,
  input  res_t                push_second,
  output logic [CNT_BITS-1:0] count,
  sbt_out_if.source           tokens
);

  res_t                entries [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic                pop;
  res_t                head;

  assign pop  = tokens.valid && tokens.ready;
  assign head = entries[rd_ptr];

  // Drive the output channel from the head entry
  assign tokens.valid        = (count != '0);
  assign tokens.event_res    = head.event_res;
  assign tokens.token_kind   = head.token_kind;
  assign tokens.text_byte    = head.text_byte;
  assign tokens.token_line   = head.token_line;
  assign tokens.token_column = head.token_column;
  assign tokens.last         = head.last;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push_first;
    if (push_count == 2'd2) entries[wr_ptr + PTR_BITS'(1)] <= push_second;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      if (pop) rd_ptr <= rd_ptr + PTR_BITS'(1);
      count <= count + CNT_BITS'(push_count) - CNT_BITS'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FIFO_DEPTH))
    else $error("result queue above depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> (count + CNT_BITS'(push_count) <= CNT_BITS'(FIFO_DEPTH)))
    else $error("result pushed into full queue");

endmodule

### sv/sexpr_byte_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_byte_tokenizer: s-expression lexer, one source byte per transfer
//
//   Port    Dir  Carries
//   bytes   in   byte_value, end_of_input
//   tokens  out  event_res, token_kind, text_byte, token_line,
//                token_column, last
//
// A byte is taken into an input register and scanned once the 4-entry
// queue has room for two results; it writes 0..2 results there. Throughput
// is one byte per cycle while the queue has that room; a byte that ends a
// token and also yields a paren, text or end event writes two results, and
// the single output port drains them one per transfer. Reset clears
// scanner state (line 1, column 0) and the queue. A stalled output fills the
// queue; past two results it holds the input register and drops bytes.ready.
// ----------------------------------------------------------------------------
module sexpr_byte_tokenizer import sbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sbt_in_if.sink    bytes,
  sbt_out_if.source tokens
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_eof;
  logic                advance;
  logic [CNT_BITS-1:0] fifo_count;
  state_t              state;
  step_t               step;

  // Scan the held byte once the queue has room for two results
  assign advance     = in_valid && (fifo_count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign bytes.ready = !in_valid || advance;

  // Input register: load on transfer, drop once scanned
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.byte_value;
      in_eof  <= bytes.end_of_input;
    end
  end

  sbt_step u_step (
    .state        (state),
    .byte_value   (in_byte),
    .end_of_input (in_eof),
    .step         (step)
  );

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= MODE_IDLE;
      state.line         <= LINE_BITS'(1);
      state.column       <= '0;
      state.start_line   <= LINE_BITS'(1);
      state.start_column <= '0;
    end else if (advance) begin
      state <= step.nxt;
    end
  end

  sbt_res_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (advance ? step.count : 2'd0),
    .push_first  (step.first),
    .push_second (step.second),
    .count       (fifo_count),
    .tokens      (tokens)
  );

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.line != '0)
    else $error("line counter reached zero");

  a_pair_after_done: assert property (@(posedge clk) disable iff (rst)
    (advance && step.count == 2'd2) |-> (step.first.event_res == EV_DONE))
    else $error("second result without token end");

  a_text_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && step.count != 2'd0 && step.first.event_res == EV_TEXT)
      |=> (state.mode == MODE_INTEGER || state.mode == MODE_IDENT))
    else $error("text byte left scanner outside a token");

endmodule
